>>> hdl/npc_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the normal projection block.
// No dependencies; used by all files but npc_sqrt and npc_div.
package npc_pkg;

   localparam int COMPONENT_WIDTH_DEF = 16;
   localparam int FIELD_W = 16;
   localparam int OUT_W = 20;
   localparam int SQ_W = 31;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int C_W = 19;
   localparam int L12_W = 19;
   localparam int LSUM_W = 38;

   // One classified word as it passes from the front end to the back end.
   typedef struct packed {
      logic [2:0][FIELD_W-1:0] n;
      logic [2:0][FIELD_W-1:0] v;
      logic [2:0][SQ_W-1:0]    sq;
   } front_word_type;

endpackage

>>> hdl/npc_sqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage, with remainder.
// Depends on nothing but its parameters.
module npc_sqrt #(
   parameter int IW = 64,
   parameter int CTXW = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [IW-1:0]       in_radicand,
   input  logic [CTXW-1:0]     in_ctx,
   output logic                out_valid,
   output logic [IW/2-1:0]     out_root,
   output logic [IW-1:0]       out_rem,
   output logic [CTXW-1:0]     out_ctx
);
   localparam int OW = IW / 2;

   logic          valid_ff [OW];
   logic [IW-1:0] rem_ff   [OW];
   logic [OW-1:0] root_ff  [OW];
   logic [CTXW-1:0] ctx_ff [OW];

   for (genvar k = 0; k < OW; k++) begin : g_stage
      localparam int B = OW - 1 - k;
      logic          src_valid;
      logic [IW-1:0] src_rem;
      logic [OW-1:0] src_root;
      logic [CTXW-1:0] src_ctx;
      logic [IW-1:0] cand;
      logic          take;

      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_rem   = in_radicand;
         assign src_root  = '0;
         assign src_ctx   = in_ctx;
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign src_rem   = rem_ff[k-1];
         assign src_root  = root_ff[k-1];
         assign src_ctx   = ctx_ff[k-1];
      end

      // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
      assign cand = (IW'(src_root) << (B + 1)) + (IW'(1) << (2 * B));
      assign take = (src_rem >= cand);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= take ? (src_rem - cand) : src_rem;
         root_ff[k] <= take ? (src_root | (OW'(1) << B)) : src_root;
         ctx_ff[k]  <= src_ctx;
      end
   end

   assign out_valid = valid_ff[OW-1];
   assign out_root  = root_ff[OW-1];
   assign out_rem   = rem_ff[OW-1];
   assign out_ctx   = ctx_ff[OW-1];

endmodule

>>> hdl/npc_div.sv
`timescale 1ns / 1ps
// Three-lane pipelined restoring divider sharing one divisor, one quotient
// bit per stage. Depends on nothing but its parameters.
module npc_div #(
   parameter int NW = 46,
   parameter int DW = 32,
   parameter int QW = 15,
   parameter int CTXW = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  logic [NW-1:0]   in_num [3],
   input  logic [DW-1:0]   in_den,
   input  logic [CTXW-1:0] in_ctx,
   output logic            out_valid,
   output logic [QW-1:0]   out_quot [3],
   output logic [CTXW-1:0] out_ctx
);
   logic            valid_ff [QW];
   logic [DW-1:0]   den_ff   [QW];
   logic [CTXW-1:0] ctx_ff   [QW];
   logic [DW-1:0]   rem_ff   [QW][3];
   logic [QW-1:0]   lo_ff    [QW][3];
   logic [QW-1:0]   quot_ff  [QW][3];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic            src_valid;
      logic [DW-1:0]   src_den;
      logic [CTXW-1:0] src_ctx;
      logic [DW-1:0]   src_rem  [3];
      logic [QW-1:0]   src_lo   [3];
      logic [QW-1:0]   src_quot [3];
      logic [DW-1:0]   nxt_rem  [3];
      logic [QW-1:0]   nxt_quot [3];

      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_den   = in_den;
         assign src_ctx   = in_ctx;
         for (genvar j = 0; j < 3; j++) begin : g_lane
            // The quotient fits in QW bits, so the upper part is below the divisor.
            assign src_rem[j]  = DW'(in_num[j] >> QW);
            assign src_lo[j]   = in_num[j][QW-1:0];
            assign src_quot[j] = '0;
         end
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign src_den   = den_ff[k-1];
         assign src_ctx   = ctx_ff[k-1];
         for (genvar j = 0; j < 3; j++) begin : g_lane
            assign src_rem[j]  = rem_ff[k-1][j];
            assign src_lo[j]   = lo_ff[k-1][j];
            assign src_quot[j] = quot_ff[k-1][j];
         end
      end

      always_comb begin
         logic [DW:0] trial;
         logic        ge;
         for (int j = 0; j < 3; j++) begin
            trial = {src_rem[j], src_lo[j][QW-1]};
            ge = (trial >= {1'b0, src_den});
            nxt_rem[j]  = ge ? DW'(trial - {1'b0, src_den}) : DW'(trial);
            nxt_quot[j] = {src_quot[j][QW-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         den_ff[k] <= src_den;
         ctx_ff[k] <= src_ctx;
         for (int j = 0; j < 3; j++) begin
            rem_ff[k][j]  <= nxt_rem[j];
            lo_ff[k][j]   <= src_lo[j] << 1;
            quot_ff[k][j] <= nxt_quot[j];
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_ctx   = ctx_ff[QW-1];
   for (genvar j = 0; j < 3; j++) begin : g_out
      assign out_quot[j] = quot_ff[QW-1][j];
   end

endmodule

>>> hdl/npc_front.sv
`timescale 1ns / 1ps
// Front end: takes a command word, squares the normal's components and
// hands the word to the queue. Depends on npc_pkg.
module npc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [15:0]            req_normal_x,
   input  logic signed [15:0]            req_normal_y,
   input  logic signed [15:0]            req_normal_z,
   input  logic signed [15:0]            req_disp_x,
   input  logic signed [15:0]            req_disp_y,
   input  logic signed [15:0]            req_disp_z,
   input  logic                          queue_full,
   output logic                          push,
   output npc_pkg::front_word_type       word
);
   import npc_pkg::*;

   logic           valid_ff, valid_in;
   front_word_type word_ff, word_in;
   logic signed [31:0] sq_x, sq_y, sq_z;
   logic           accept;

   assign busy   = valid_ff & queue_full;
   assign accept = start & ~busy;
   assign push   = valid_ff & ~queue_full;
   assign word   = word_ff;

   always_comb begin
      sq_x = req_normal_x * req_normal_x;
      sq_y = req_normal_y * req_normal_y;
      sq_z = req_normal_z * req_normal_z;
      word_in.n  = {req_normal_z, req_normal_y, req_normal_x};
      word_in.v  = {req_disp_z, req_disp_y, req_disp_x};
      word_in.sq = {sq_z[SQ_W-1:0], sq_y[SQ_W-1:0], sq_x[SQ_W-1:0]};
      if (accept) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= word_in;
      end
   end

endmodule

>>> hdl/npc_queue.sv
`timescale 1ns / 1ps
// Short queue between front and back end. The back end takes a word
// whenever one is present. Depends on npc_pkg.
module npc_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  npc_pkg::front_word_type push_word,
   output logic                    full,
   output logic                    pop,
   output npc_pkg::front_word_type pop_word
);
   import npc_pkg::*;

   front_word_type    mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   count_ff, count_in;

   assign full     = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign pop      = (count_ff != '0);
   assign pop_word = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

>>> hdl/npc_back.sv
`timescale 1ns / 1ps
// Back end: normal length, unit normal, dot product and lateral length,
// fully pipelined. Depends on npc_pkg, npc_sqrt and npc_div.
module npc_back #(
   parameter int COMPONENT_WIDTH = npc_pkg::COMPONENT_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  npc_pkg::front_word_type in_word,
   input  logic                    lateral_mode,
   output logic                    rsp_strobe,
   output logic signed [19:0]      rsp_component,
   output logic                    rsp_zero_normal
);
   import npc_pkg::*;

   localparam int F     = COMPONENT_WIDTH - 2;
   localparam int QW    = F + 1;
   localparam int UW    = F + 2;
   localparam int PW    = UW + FIELD_W;
   localparam int DSW   = PW + 2;
   localparam int CUW   = C_W + UW;
   localparam int LW    = CUW + 1;
   localparam int NW    = F + 32;
   localparam int RW    = 32;
   localparam int CTX1W = 6 * FIELD_W + 1;
   localparam int CTX2W = 3 * FIELD_W + 4;
   localparam int CTX3W = C_W + 1;
   localparam logic [DSW-1:0] HALF_D = DSW'(1) << (F - 1);
   localparam logic [LW-1:0]  HALF_L = LW'(1) << (F - 1);

   // Sum of squares and zero test.
   logic          s0_valid_ff;
   logic [31:0]   s0_s_ff;
   logic [2:0][FIELD_W-1:0] s0_n_ff, s0_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      s0_s_ff <= 32'(in_word.sq[0]) + 32'(in_word.sq[1]) + 32'(in_word.sq[2]);
      s0_n_ff <= in_word.n;
      s0_v_ff <= in_word.v;
   end

   // Normal length with 15 extra fraction bits.
   logic             r1_valid;
   logic [RW-1:0]    r1_root;
   logic [CTX1W-1:0] r1_ctx;
   logic [2:0][FIELD_W-1:0] r1_n, r1_v;
   logic             r1_zero;

   npc_sqrt #(.IW(2 * RW), .CTXW(CTX1W)) u_norm_sqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s0_valid_ff),
      .in_radicand ({2'b00, s0_s_ff, 30'd0}),
      .in_ctx      ({s0_n_ff, s0_v_ff, (s0_s_ff == 32'd0)}),
      .out_valid   (r1_valid),
      .out_root    (r1_root),
      .out_rem     (),
      .out_ctx     (r1_ctx)
   );

   assign {r1_n, r1_v, r1_zero} = r1_ctx;

   logic [NW-1:0] div_num [3];
   logic [2:0]    n_neg;

   always_comb begin
      logic [FIELD_W-1:0] a;
      for (int j = 0; j < 3; j++) begin
         n_neg[j] = r1_n[j][FIELD_W-1];
         a = n_neg[j] ? FIELD_W'(-r1_n[j]) : r1_n[j];
         div_num[j] = (NW'(a) << (F + 15)) + NW'(r1_root >> 1);
      end
   end

   // Unit normal, rounded to nearest.
   logic             q_valid;
   logic [QW-1:0]    q_quot [3];
   logic [CTX2W-1:0] q_ctx;
   logic [2:0]       q_neg;
   logic [2:0][FIELD_W-1:0] q_v;
   logic             q_zero;

   npc_div #(.NW(NW), .DW(RW), .QW(QW), .CTXW(CTX2W)) u_unit_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (r1_valid),
      .in_num    (div_num),
      .in_den    (r1_root),
      .in_ctx    ({n_neg, r1_v, r1_zero}),
      .out_valid (q_valid),
      .out_quot  (q_quot),
      .out_ctx   (q_ctx)
   );

   assign {q_neg, q_v, q_zero} = q_ctx;

   // Arithmetic pipeline after the divider.
   logic [7:0] pv_ff;

   logic signed [UW-1:0]  u0_ff [3], u1_ff [3], u2_ff [3], u3_ff [3];
   logic [2:0][FIELD_W-1:0] v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;
   logic z0_ff, z1_ff, z2_ff, z3_ff, z4_ff, z5_ff, z6_ff, z7_ff;
   logic signed [PW-1:0]  prod_ff [3];
   logic signed [DSW-1:0] d_ff;
   logic signed [C_W-1:0] c3_ff, c4_ff, c5_ff, c6_ff, c7_ff;
   logic signed [CUW-1:0] cu_ff [3];
   logic signed [L12_W-1:0] l12_ff [3];
   logic [2*L12_W-1:0]    lsq_ff [3];
   logic [LSUM_W-1:0]     lsum_ff;

   logic signed [C_W-1:0]   c_rnd;
   logic signed [L12_W-1:0] l12_rnd [3];

   always_comb begin
      logic [DSW-1:0] d_mag;
      logic [DSW-1:0] c_mag;
      d_mag = d_ff[DSW-1] ? DSW'(-d_ff) : DSW'(d_ff);
      c_mag = (d_mag + HALF_D) >> F;
      c_rnd = d_ff[DSW-1] ? -C_W'(c_mag) : C_W'(c_mag);
   end

   always_comb begin
      logic signed [LW-1:0] lv;
      logic [LW-1:0]        l_mag;
      logic [LW-1:0]        m;
      for (int j = 0; j < 3; j++) begin
         lv = (LW'($signed(v4_ff[j])) <<< F) - LW'(cu_ff[j]);
         l_mag = lv[LW-1] ? LW'(-lv) : LW'(lv);
         m = (l_mag + HALF_L) >> F;
         l12_rnd[j] = lv[LW-1] ? -L12_W'(m) : L12_W'(m);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= '0;
      end else begin
         pv_ff <= {pv_ff[6:0], q_valid};
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         if (q_zero) begin
            u0_ff[j] <= '0;
         end else begin
            u0_ff[j] <= q_neg[j] ? -UW'(q_quot[j]) : UW'(q_quot[j]);
         end
         prod_ff[j] <= u0_ff[j] * $signed(v0_ff[j]);
         u1_ff[j]   <= u0_ff[j];
         u2_ff[j]   <= u1_ff[j];
         u3_ff[j]   <= u2_ff[j];
         cu_ff[j]   <= c3_ff * u3_ff[j];
         l12_ff[j]  <= l12_rnd[j];
         lsq_ff[j]  <= (2 * L12_W)'(l12_ff[j] * l12_ff[j]);
      end
      v0_ff <= q_v;
      v1_ff <= v0_ff;
      v2_ff <= v1_ff;
      v3_ff <= v2_ff;
      v4_ff <= v3_ff;
      z0_ff <= q_zero;
      z1_ff <= z0_ff;
      z2_ff <= z1_ff;
      z3_ff <= z2_ff;
      z4_ff <= z3_ff;
      z5_ff <= z4_ff;
      z6_ff <= z5_ff;
      z7_ff <= z6_ff;
      d_ff  <= DSW'(prod_ff[0]) + DSW'(prod_ff[1]) + DSW'(prod_ff[2]);
      c3_ff <= c_rnd;
      c4_ff <= c3_ff;
      c5_ff <= c4_ff;
      c6_ff <= c5_ff;
      c7_ff <= c6_ff;
      lsum_ff <= LSUM_W'(lsq_ff[0]) + LSUM_W'(lsq_ff[1]) + LSUM_W'(lsq_ff[2]);
   end

   // Lateral length.
   logic                 r2_valid;
   logic [LSUM_W/2-1:0]  r2_root;
   logic [LSUM_W-1:0]    r2_rem;
   logic [CTX3W-1:0]     r2_ctx;
   logic signed [C_W-1:0] r2_c;
   logic                 r2_zero;

   npc_sqrt #(.IW(LSUM_W), .CTXW(CTX3W)) u_lat_sqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (pv_ff[7]),
      .in_radicand (lsum_ff),
      .in_ctx      ({c7_ff, z7_ff}),
      .out_valid   (r2_valid),
      .out_root    (r2_root),
      .out_rem     (r2_rem),
      .out_ctx     (r2_ctx)
   );

   assign {r2_c, r2_zero} = r2_ctx;

   logic                    strobe_ff;
   logic signed [OUT_W-1:0] comp_ff, comp_in;
   logic                    zero_ff;

   always_comb begin
      logic [OUT_W-1:0] rnd;
      // Round to nearest: step up when the remainder exceeds the root.
      rnd = OUT_W'(r2_root) + OUT_W'(r2_rem > LSUM_W'(r2_root));
      if (lateral_mode) begin
         comp_in = rnd[OUT_W-1] ? {1'b0, {(OUT_W - 1){1'b1}}} : rnd;
      end else begin
         comp_in = OUT_W'(r2_c);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= r2_valid;
      end
   end

   always_ff @(posedge clock) begin
      comp_ff <= comp_in;
      zero_ff <= r2_zero;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_component   = comp_ff;
   assign rsp_zero_normal = zero_ff;

endmodule

>>> hdl/normal_projection_component_top.sv
`timescale 1ns / 1ps
// Normal projection of a displacement onto a unit surface normal.
// Instantiates npc_front, npc_queue and npc_back; depends on npc_pkg.
//
// Usage: drive the six Q4.12 fields and raise start; the word is taken at
// a rising edge where start is high and busy is low. One word can be taken
// every cycle while busy is low. The result appears on rsp_component and
// rsp_zero_normal for exactly one cycle, flagged by rsp_strobe. Its path
// runs through the two bit-per-stage square root pipelines (32 and 19
// stages) and the divider pipeline of COMPONENT_WIDTH - 1 stages.
// The receiver cannot hold results off, and the back end never stalls, so
// busy stays low in normal operation; the queue only absorbs the front end.
// The mode register is written through csr_valid/csr_ready, which is always
// ready; write it only while no word is in flight.
// Synchronous reset clears all valid flags and sets the mode to normal
// projection; words in flight are dropped.
module normal_projection_component_top #(
   parameter int COMPONENT_WIDTH = npc_pkg::COMPONENT_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_normal_x,
   input  logic signed [15:0] req_normal_y,
   input  logic signed [15:0] req_normal_z,
   input  logic signed [15:0] req_disp_x,
   input  logic signed [15:0] req_disp_y,
   input  logic signed [15:0] req_disp_z,
   output logic               rsp_strobe,
   output logic signed [19:0] rsp_component,
   output logic               rsp_zero_normal,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_lateral_mode
);
   import npc_pkg::*;

   logic           lateral_mode_ff;
   logic           queue_full;
   logic           push;
   front_word_type push_word;
   logic           pop;
   front_word_type pop_word;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lateral_mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         lateral_mode_ff <= csr_lateral_mode;
      end
   end

   npc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_normal_x (req_normal_x),
      .req_normal_y (req_normal_y),
      .req_normal_z (req_normal_z),
      .req_disp_x   (req_disp_x),
      .req_disp_y   (req_disp_y),
      .req_disp_z   (req_disp_z),
      .queue_full   (queue_full),
      .push         (push),
      .word         (push_word)
   );

   npc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .full      (queue_full),
      .pop       (pop),
      .pop_word  (pop_word)
   );

   npc_back #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_back (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (pop),
      .in_word         (pop_word),
      .lateral_mode    (lateral_mode_ff),
      .rsp_strobe      (rsp_strobe),
      .rsp_component   (rsp_component),
      .rsp_zero_normal (rsp_zero_normal)
   );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for normal_projection_component_top: random and directed
// words, predicted results compared field by field. Depends on npc_pkg and the RTL.
module testbench;

   localparam int CW = npc_pkg::COMPONENT_WIDTH_DEF;
   localparam int FB = CW - 2;
   localparam int LATENCY = CW + 61;

   typedef struct packed {
      logic signed [15:0] nx, ny, nz, vx, vy, vz;
   } point_word_t;

   typedef struct packed {
      logic signed [19:0] component;
      logic               zero_normal;
   } projection_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [15:0] req_normal_x = '0, req_normal_y = '0, req_normal_z = '0;
   logic signed [15:0] req_disp_x = '0, req_disp_y = '0, req_disp_z = '0;
   logic rsp_strobe;
   logic signed [19:0] rsp_component;
   logic rsp_zero_normal;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_lateral_mode = 1'b0;

   normal_projection_component_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_normal_x(req_normal_x), .req_normal_y(req_normal_y),
      .req_normal_z(req_normal_z), .req_disp_x(req_disp_x),
      .req_disp_y(req_disp_y), .req_disp_z(req_disp_z),
      .rsp_strobe(rsp_strobe), .rsp_component(rsp_component),
      .rsp_zero_normal(rsp_zero_normal), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_lateral_mode(csr_lateral_mode)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   point_word_t pending_words[$];
   projection_t expected_projections[$];
   logic lateral_mode = 1'b0;
   int idle_percent = 0;
   int fault_count = 0;

   function automatic logic [63:0] isqrt(logic [63:0] x);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic longint round_away(longint x);
      longint m;
      m = (x < 0) ? -x : x;
      m = (m + (64'sd1 <<< (FB - 1))) >>> FB;
      return (x < 0) ? -m : m;
   endfunction

   function automatic longint clamp_q8_12(longint x);
      if (x > 524287) return 524287;
      if (x < -524288) return -524288;
      return x;
   endfunction

   function automatic projection_t project_point(point_word_t w, logic lateral);
      longint n[3], v[3], u[3], d, c, res, l, l12, a;
      logic [63:0] s, r, q, lsum, root;
      projection_t p;
      n = '{w.nx, w.ny, w.nz};
      v = '{w.vx, w.vy, w.vz};
      u = '{0, 0, 0};
      s = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
      if (s != 0) begin
         r = isqrt(s << 30);
         for (int i = 0; i < 3; i++) begin
            a = (n[i] < 0) ? -n[i] : n[i];
            q = ((a << (FB + 15)) + (r >> 1)) / r;
            u[i] = (n[i] < 0) ? -longint'(q) : longint'(q);
         end
      end
      d = u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
      c = round_away(d);
      if (lateral) begin
         lsum = 0;
         for (int i = 0; i < 3; i++) begin
            l = v[i] * (64'sd1 <<< FB) - c * u[i];
            l12 = round_away(l);
            lsum += l12 * l12;
         end
         root = isqrt(lsum);
         if (lsum > root * root + root) root++;
         res = clamp_q8_12(longint'(root));
      end else begin
         res = clamp_q8_12(c);
      end
      p.component = res[19:0];
      p.zero_normal = (s == 0);
      return p;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fault_count++;
   endtask

   // Driver: a word is taken at a rising edge with start high and busy low.
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         expected_projections.push_back(project_point(pending_words.pop_front(),
                                                      lateral_mode));
      end
   end

   always @(negedge clock) begin
      point_word_t w;
      if (reset) begin
         start <= 1'b0;
      end else if (pending_words.size() > 0 && $urandom_range(99) >= idle_percent) begin
         w = pending_words[0];
         start <= 1'b1;
         {req_normal_x, req_normal_y, req_normal_z} <= {w.nx, w.ny, w.nz};
         {req_disp_x, req_disp_y, req_disp_z} <= {w.vx, w.vy, w.vz};
      end else begin
         start <= 1'b0;
      end
   end

   // Monitor.
   always @(posedge clock) begin
      projection_t want;
      if (!reset && rsp_strobe) begin
         if (expected_projections.size() == 0) begin
            report_mismatch("unexpected word", rsp_component, 0);
         end else begin
            want = expected_projections.pop_front();
            if (rsp_component !== want.component)
               report_mismatch("component", rsp_component, want.component);
            if (rsp_zero_normal !== want.zero_normal)
               report_mismatch("zero_normal", rsp_zero_normal, want.zero_normal);
         end
      end
   end

   function automatic logic signed [15:0] random_field();
      case ($urandom_range(9))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'(0);
         3: return 16'(signed'($urandom_range(8)) - 4);
         4: return 16'(signed'($urandom_range(8192)) - 4096);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic add_word(int nx, int ny, int nz, int vx, int vy, int vz);
      point_word_t w;
      w = '{16'(nx), 16'(ny), 16'(nz), 16'(vx), 16'(vy), 16'(vz)};
      pending_words.push_back(w);
   endtask

   task automatic drain();
      while (pending_words.size() > 0 || expected_projections.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_mode(logic m);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_lateral_mode <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      lateral_mode = m;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic directed_words();
      add_word(0, 0, 0, 4096, -4096, 100);
      add_word(0, 0, 0, -32768, -32768, -32768);
      add_word(4096, 0, 0, 4096, 2048, -1024);
      add_word(0, -4096, 0, 32767, -32768, 5);
      add_word(0, 0, 1, -3, 7, 32767);
      add_word(-32768, -32768, -32768, -32768, -32768, -32768);
      add_word(32767, 32767, 32767, 32767, 32767, 32767);
      add_word(-32768, 32767, 0, 32767, -32768, 0);
      add_word(1, 1, 1, 1, -1, 0);
      add_word(-1, 0, 0, 32767, 32767, 32767);
      add_word(2896, 2896, 0, -32768, 32767, -32768);
   endtask

   task automatic random_words(int count);
      point_word_t w;
      for (int i = 0; i < count; i++) begin
         w = '{random_field(), random_field(), random_field(),
               random_field(), random_field(), random_field()};
         if ($urandom_range(19) == 0) {w.nx, w.ny, w.nz} = '0;
         pending_words.push_back(w);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      directed_words();
      drain();
      write_mode(1'b1);
      directed_words();
      idle_percent = 24;
      random_words(140);
      drain();
      write_mode(1'b0);
      random_words(140);
      drain();
      idle_percent = 72;
      write_mode(1'b1);
      random_words(140);
      drain();
      write_mode(1'b0);
      random_words(140);
      drain();
      idle_percent = 0;
      random_words(140);
      drain();
      write_mode(1'b1);
      random_words(140);
      drain();
      if (fault_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> filelist.f
hdl/npc_pkg.sv
hdl/npc_sqrt.sv
hdl/npc_div.sv
hdl/npc_front.sv
hdl/npc_queue.sv
hdl/npc_back.sv
hdl/normal_projection_component_top.sv
tb/testbench.sv
